[hw/rtl/ntc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ntc_pkg;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [3:0] {
		FN_I2L = 4'd0, FN_I2F = 4'd1, FN_I2D = 4'd2, FN_L2I = 4'd3,
		FN_L2F = 4'd4, FN_L2D = 4'd5, FN_F2I = 4'd6, FN_F2L = 4'd7,
		FN_F2D = 4'd8, FN_D2I = 4'd9, FN_D2L = 4'd10, FN_D2F = 4'd11,
		FN_I2B = 4'd12, FN_I2C = 4'd13, FN_I2S = 4'd14, FN_NONE = 4'd15
	} func_t;

	// operation class chosen by the front end
	typedef enum logic [2:0] {
		OP_ZERO = 3'd0, OP_PASS = 3'd1, OP_I2FP = 3'd2, OP_FP2I = 3'd3, OP_FP2FP = 3'd4
	} op_t;

	// unpacked operand handed to the back end
	typedef struct packed {
		op_t         op;
		logic        dst_dbl;   // fp destination is double
		logic        dst_long;  // int destination is 64 bit
		logic        wide;
		logic        sign;
		logic        is_nan;
		logic        is_inf;
		logic [63:0] mag;       // integer magnitude, fp significand, or pass value
		logic signed [12:0] exp; // value = mag * 2^exp
	} uop_t;
endpackage
`default_nettype wire

[hw/rtl/ntc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ntc_front (
	input  wire logic [3:0]    func,
	input  wire logic [63:0]   operand_bits,
	output ntc_pkg::uop_t      uop
);
	import ntc_pkg::*;
	logic [31:0] lo;
	logic [63:0] neg64;
	logic [31:0] neg32;
	always_comb begin
		lo = operand_bits[31:0];
		neg32 = 32'd0 - lo;
		neg64 = 64'd0 - operand_bits;
		uop = '0;
		unique case (func_t'(func))
			FN_I2L: begin
				uop.op = OP_PASS; uop.wide = 1'b1;
				uop.mag = {{32{lo[31]}}, lo};
			end
			FN_L2I: begin uop.op = OP_PASS; uop.mag = {32'd0, lo}; end
			FN_I2B: begin uop.op = OP_PASS; uop.mag = {32'd0, {24{lo[7]}}, lo[7:0]}; end
			FN_I2C: begin uop.op = OP_PASS; uop.mag = {48'd0, lo[15:0]}; end
			FN_I2S: begin uop.op = OP_PASS; uop.mag = {32'd0, {16{lo[15]}}, lo[15:0]}; end
			FN_I2F, FN_I2D: begin
				uop.op = OP_I2FP; uop.sign = lo[31];
				uop.dst_dbl = (func_t'(func) == FN_I2D); uop.wide = uop.dst_dbl;
				uop.mag = {32'd0, lo[31] ? neg32 : lo};
			end
			FN_L2F, FN_L2D: begin
				uop.op = OP_I2FP; uop.sign = operand_bits[63];
				uop.dst_dbl = (func_t'(func) == FN_L2D); uop.wide = uop.dst_dbl;
				uop.mag = operand_bits[63] ? neg64 : operand_bits;
			end
			FN_F2I, FN_F2L, FN_F2D: begin
				uop.op = (func_t'(func) == FN_F2D) ? OP_FP2FP : OP_FP2I;
				uop.dst_long = (func_t'(func) == FN_F2L);
				uop.dst_dbl = 1'b1;
				uop.wide = (func_t'(func) != FN_F2I);
				uop.sign = lo[31];
				uop.is_nan = (&lo[30:23]) && (|lo[22:0]);
				uop.is_inf = (&lo[30:23]) && !(|lo[22:0]);
				uop.mag = {40'd0, |lo[30:23], lo[22:0]};
				uop.exp = (lo[30:23] == 8'd0) ? -13'sd149
					: $signed({5'd0, lo[30:23]}) - 13'sd150;
			end
			FN_D2I, FN_D2L, FN_D2F: begin
				uop.op = (func_t'(func) == FN_D2F) ? OP_FP2FP : OP_FP2I;
				uop.dst_long = (func_t'(func) == FN_D2L);
				uop.wide = uop.dst_long;
				uop.sign = operand_bits[63];
				uop.is_nan = (&operand_bits[62:52]) && (|operand_bits[51:0]);
				uop.is_inf = (&operand_bits[62:52]) && !(|operand_bits[51:0]);
				uop.mag = {11'd0, |operand_bits[62:52], operand_bits[51:0]};
				uop.exp = (operand_bits[62:52] == 11'd0) ? -13'sd1074
					: $signed({2'd0, operand_bits[62:52]}) - 13'sd1075;
			end
			default: uop.op = OP_ZERO;
		endcase
	end
endmodule
`default_nettype wire

[hw/rtl/ntc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module ntc_queue #(
	parameter int unsigned Depth = ntc_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ntc_pkg::uop_t push_data,
	input  wire logic          pop,
	output ntc_pkg::uop_t      head,
	output logic               not_empty,
	output logic               full
);
	import ntc_pkg::*;
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	uop_t          mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	assign not_empty = (cnt_q != '0);
	assign full = (cnt_q == (AW+1)'(Depth));
	assign head = mem_q[rd_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

[hw/rtl/ntc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module ntc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire ntc_pkg::uop_t in_uop,
	output logic               done,
	output logic [63:0]        result_bits,
	output logic               result_wide
);
	import ntc_pkg::*;
	// stage 1: normalize
	logic [5:0]  lz;
	logic        lz_found;
	logic [63:0] norm;
	logic signed [13:0] big_e;
	always_comb begin
		lz = 6'd0; lz_found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!lz_found && in_uop.mag[i]) begin
				lz = 6'(63 - i); lz_found = 1'b1;
			end
		end
		norm = in_uop.mag << lz;
		big_e = 14'(in_uop.exp) + 14'sd63 - $signed({8'd0, lz});
	end
	logic        v_s1;
	uop_t        u_s1;
	logic [63:0] norm_s1;
	logic signed [13:0] be_s1;
	logic        nz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		u_s1 <= in_uop; norm_s1 <= norm; be_s1 <= big_e; nz_s1 <= lz_found;
	end

	// stage 2: round, pack or truncate
	logic [63:0] r;
	logic signed [13:0] bias, be, shamt, eff;
	logic [5:0]  fb;
	logic [6:0]  sh;
	logic [63:0] q, stk_mask, packed_v, expmax, mag, lim;
	logic        rb, st, ovf;
	logic [6:0]  rsh;
	always_comb begin
		r = '0; q = '0; rb = 1'b0; st = 1'b0; eff = '0; packed_v = '0; stk_mask = '0;
		fb = u_s1.dst_dbl ? 6'd52 : 6'd23;
		bias = u_s1.dst_dbl ? 14'sd1023 : 14'sd127;
		expmax = u_s1.dst_dbl ? 64'h7FF0_0000_0000_0000 : 64'h7F80_0000;
		be = be_s1 + bias;
		shamt = 14'sd63 - 14'($unsigned(fb));
		if (be < 14'sd1) shamt = shamt + 14'sd1 - be;
		sh = (shamt > 14'sd64) ? 7'd65 : 7'(shamt);
		if (sh == 7'd64) begin
			rb = norm_s1[63]; st = |norm_s1[62:0];
		end else if (sh < 7'd64) begin
			q = norm_s1 >> sh[5:0];
			rb = norm_s1[sh[5:0] - 6'd1];
			stk_mask = (64'd1 << (sh[5:0] - 6'd1)) - 64'd1;
			st = |(norm_s1 & stk_mask);
		end
		if (rb && (st || q[0])) q = q + 64'd1;
		eff = (be < 14'sd1) ? 14'sd0 : be - 14'sd1;
		if (!nz_s1 || sh > 7'd64) packed_v = '0;
		else if (be_s1 > bias) packed_v = expmax;
		else packed_v = (64'($unsigned(eff[10:0])) << fb) + q;
		packed_v = packed_v | (64'(u_s1.sign) << (u_s1.dst_dbl ? 7'd63 : 7'd31));
		// truncation toward zero
		lim = u_s1.dst_long ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
		ovf = u_s1.is_inf || (nz_s1 && be_s1 > 14'sd62);
		rsh = (be_s1 < 14'sd0) ? 7'd64 : 7'(14'sd63 - be_s1);
		mag = (!nz_s1 || rsh[6]) ? 64'd0 : norm_s1 >> rsh[5:0];
		case (u_s1.op)
			OP_PASS: r = u_s1.mag;
			OP_I2FP: r = packed_v;
			OP_FP2FP: begin
				if (u_s1.is_nan)
					r = u_s1.dst_dbl ? 64'h7FF8_0000_0000_0000 : 64'h7FC0_0000;
				else if (u_s1.is_inf)
					r = expmax | (64'(u_s1.sign) << (u_s1.dst_dbl ? 7'd63 : 7'd31));
				else r = packed_v;
			end
			OP_FP2I: begin
				if (u_s1.is_nan) r = '0;
				else if (u_s1.sign) r = (ovf || mag > lim) ? lim : 64'd0 - mag;
				else r = (ovf || mag > lim - 64'd1) ? lim - 64'd1 : mag;
			end
			default: r = '0;
		endcase
		if (!u_s1.wide) r[63:32] = 32'd0;
	end
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		result_bits <= r; result_wide <= u_s1.wide;
	end
	assign done = v_s2;
endmodule
`default_nettype wire

[hw/rtl/numeric_type_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Converts one operand between int, long, float and double (the fifteen JVM
// conversion opcodes, including byte/char/short narrowing). One item per cycle:
// the front end decodes and unpacks, a two-entry queue decouples it from a
// two-stage back end (normalize, then round/truncate/pack). The back end
// never stalls, since the receiver cannot hold results off, so busy stays low
// and each result appears with done once it has passed the queue and both stages.
module numeric_type_converter #(
	parameter int unsigned QDepth = ntc_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  func,
	input  wire logic [63:0] operand_bits,
	output logic             done,
	output logic [63:0]      result_bits,
	output logic             result_wide
);
	import ntc_pkg::*;
	uop_t fuop, head;
	logic ne, full, push;
	ntc_front u_front (.func(func), .operand_bits(operand_bits), .uop(fuop));
	assign busy = full;
	assign push = start && !busy;
	ntc_queue #(.Depth(QDepth)) u_q (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(fuop),
		.pop(ne), .head(head), .not_empty(ne), .full(full));
	ntc_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(ne), .in_uop(head),
		.done(done), .result_bits(result_bits), .result_wide(result_wide));
`ifndef NO_ASSERTIONS
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> ##2 done) else $error("result missing");
	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result_wide |-> result_bits[63:32] == 32'd0) else $error("upper half");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("stalled");
`endif
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
import ntc_pkg::*;

module tb;
	// stimulus and expectation records
	typedef struct {
		func_t       fn;
		logic [63:0] operand;
	} conv_item_t;

	typedef struct {
		logic [63:0] bits;
		logic        wide;
	} conv_result_t;

	localparam int RandomItems = 400;
	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 12;   // generous margin beyond the block latency

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [3:0]  func = '0;
	logic [63:0] operand_bits = '0;
	logic        done;
	logic [63:0] result_bits;
	logic        result_wide;

	conv_item_t   pending_items[$];
	conv_result_t expected_results[$];
	int           send_idle_pct = 25;
	int           items_accepted = 0;
	int           cycle_count = 0;
	bit           mismatch_seen = 1'b0;
	bit           stimulus_loaded = 1'b0;

	numeric_type_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.operand_bits(operand_bits),
		.done(done),
		.result_bits(result_bits),
		.result_wide(result_wide)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Conversion predictor, all on raw bit patterns.
	// ---------------------------------------------------------------

	// sign * m * 2^e packed into fb fraction / eb exponent bits, RNE.
	function automatic logic [63:0] ieee_pack(input logic sgn, input logic [63:0] m,
			input int e, input int fb, input int eb);
		int bias, top_e, biased, shift, eff;
		logic [63:0] sbit, q, sticky;
		logic rbit;
		bias = (1 << (eb - 1)) - 1;
		sbit = 64'(sgn) << (fb + eb);
		if (m == 64'd0)
			return sbit;
		while (!m[63]) begin
			m = m << 1;
			e--;
		end
		top_e = e + 63;
		if (top_e > bias)      // overflow goes to infinity
			return sbit | (((64'd1 << eb) - 64'd1) << fb);
		biased = top_e + bias;
		shift = 63 - fb;
		if (biased < 1)        // subnormal: shift further right
			shift += 1 - biased;
		if (shift > 64)
			return sbit;
		if (shift == 64) begin
			q = 64'd0;
			rbit = m[63];
			sticky = m & ~(64'd1 << 63);
		end else begin
			q = m >> shift;
			rbit = m[shift - 1];
			sticky = m & ((64'd1 << (shift - 1)) - 64'd1);
		end
		if (rbit && (sticky != 64'd0 || q[0]))
			q = q + 64'd1;
		eff = (biased < 1) ? 0 : biased - 1;
		// rounding carry ripples into the exponent, possibly to infinity
		return sbit | ((64'(eff) << fb) + q);
	endfunction

	function automatic logic [63:0] signed_to_ieee(input logic [63:0] v, input int width,
			input int fb, input int eb);
		logic [63:0] sb, mask, mag;
		logic neg;
		sb = 64'd1 << (width - 1);
		mask = (width == 64) ? '1 : ((sb << 1) - 64'd1);
		v &= mask;
		neg = (v & sb) != 64'd0;
		mag = neg ? ((64'd0 - v) & mask) : v;
		if (neg && mag == 64'd0)
			mag = sb;
		return ieee_pack(neg, mag, 0, fb, eb);
	endfunction

	// truncate toward zero, saturate, NaN -> 0
	function automatic logic [63:0] ieee_to_signed(input logic [63:0] bits, input int fb,
			input int eb, input int w);
		int bias, e;
		logic [63:0] emax, ex, frac, lim, wmask, mant, mag;
		logic sgn, over;
		bias = (1 << (eb - 1)) - 1;
		emax = (64'd1 << eb) - 64'd1;
		sgn = bits[fb + eb];
		ex = (bits >> fb) & emax;
		frac = bits & ((64'd1 << fb) - 64'd1);
		lim = 64'd1 << (w - 1);
		wmask = (w == 64) ? '1 : ((lim << 1) - 64'd1);
		mag = 64'd0;
		over = 1'b0;
		if (ex == emax) begin
			if (frac != 64'd0)
				return 64'd0;
			over = 1'b1;
		end else begin
			if (ex == 64'd0) begin
				mant = frac;
				e = 1 - bias - fb;
			end else begin
				mant = frac | (64'd1 << fb);
				e = int'(ex) - bias - fb;
			end
			if (e < 0)
				mag = (-e >= 64) ? 64'd0 : (mant >> (-e));
			else if (e >= 64 || mant > ({64{1'b1}} >> e))
				over = 1'b1;
			else
				mag = mant << e;
		end
		if (sgn) begin
			if (over || mag > lim)
				return lim & wmask;
			return (64'd0 - mag) & wmask;
		end
		if (over || mag > lim - 64'd1)
			return lim - 64'd1;
		return mag;
	endfunction

	function automatic logic [63:0] ieee_resize(input logic [63:0] bits, input int sfb,
			input int seb, input int dfb, input int deb);
		int bias;
		logic [63:0] emax, ex, frac, dsb, dexp;
		logic sgn;
		bias = (1 << (seb - 1)) - 1;
		emax = (64'd1 << seb) - 64'd1;
		sgn = bits[sfb + seb];
		ex = (bits >> sfb) & emax;
		frac = bits & ((64'd1 << sfb) - 64'd1);
		dsb = 64'(sgn) << (dfb + deb);
		dexp = ((64'd1 << deb) - 64'd1) << dfb;
		if (ex == emax) begin
			if (frac != 64'd0)       // canonical quiet NaN
				return dexp | (64'd1 << (dfb - 1));
			return dsb | dexp;
		end
		if (ex == 64'd0)
			return ieee_pack(sgn, frac, 1 - bias - sfb, dfb, deb);
		return ieee_pack(sgn, frac | (64'd1 << sfb), int'(ex) - bias - sfb, dfb, deb);
	endfunction

	function automatic conv_result_t predict_conversion(input conv_item_t it);
		conv_result_t r;
		logic [63:0] x, lo;
		x = it.operand;
		lo = {32'd0, x[31:0]};
		r.wide = 1'b0;
		case (it.fn)
			FN_I2L: begin r.bits = {{32{lo[31]}}, lo[31:0]}; r.wide = 1'b1; end
			FN_I2F: r.bits = signed_to_ieee(lo, 32, 23, 8);
			FN_I2D: begin r.bits = signed_to_ieee(lo, 32, 52, 11); r.wide = 1'b1; end
			FN_L2I: r.bits = lo;
			FN_L2F: r.bits = signed_to_ieee(x, 64, 23, 8);
			FN_L2D: begin r.bits = signed_to_ieee(x, 64, 52, 11); r.wide = 1'b1; end
			FN_F2I: r.bits = ieee_to_signed(lo, 23, 8, 32);
			FN_F2L: begin r.bits = ieee_to_signed(lo, 23, 8, 64); r.wide = 1'b1; end
			FN_F2D: begin r.bits = ieee_resize(lo, 23, 8, 52, 11); r.wide = 1'b1; end
			FN_D2I: r.bits = ieee_to_signed(x, 52, 11, 32);
			FN_D2L: begin r.bits = ieee_to_signed(x, 52, 11, 64); r.wide = 1'b1; end
			FN_D2F: r.bits = ieee_resize(x, 52, 11, 23, 8);
			FN_I2B: r.bits = {{56{lo[7]}}, lo[7:0]};
			FN_I2C: r.bits = {48'd0, lo[15:0]};
			FN_I2S: r.bits = {{48{lo[15]}}, lo[15:0]};
			default: r.bits = 64'd0;
		endcase
		if (!r.wide)
			r.bits[63:32] = 32'd0;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Random operands: mostly values near interesting exponents, so
	// rounding, subnormals and saturation are all hit often.
	// ---------------------------------------------------------------
	function automatic logic [63:0] pick_operand();
		logic [63:0] v;
		logic [10:0] dexp;
		logic [7:0]  fexp;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 5))
			0: ;                                           // fully random bits
			1: v = {{32{v[31]}}, 32'(signed'(v[15:0]))};   // small ints
			2: begin                                       // float with edge exponent
				case ($urandom_range(0, 3))
					0: fexp = 8'($urandom_range(0, 1));
					1: fexp = 8'($urandom_range(254, 255));
					2: fexp = 8'($urandom_range(100, 200));
					default: fexp = 8'($urandom_range(120, 192));
				endcase
				v[30:23] = fexp;
				if ($urandom_range(0, 3) == 0)
					v[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
			end
			3: begin                                       // double with edge exponent
				case ($urandom_range(0, 4))
					0: dexp = 11'($urandom_range(0, 1));
					1: dexp = 11'($urandom_range(2046, 2047));
					2: dexp = 11'($urandom_range(1023, 1090));
					3: dexp = 11'($urandom_range(874, 921));   // float subnormal range and low normals
					default: dexp = 11'($urandom_range(1140, 1160)); // around float overflow
				endcase
				v[62:52] = dexp;
				if ($urandom_range(0, 3) == 0)
					v[51:0] = $urandom_range(0, 1) ? 52'd0 : {52{1'b1}};
			end
			4: v = v >> $urandom_range(0, 63);             // varied long magnitudes
			default: v = $urandom_range(0, 1) ? {1'b1, 63'd0} >> $urandom_range(0, 40)
				: {1'b0, {63{1'b1}}} >> $urandom_range(0, 40);
		endcase
		if ($urandom_range(0, 3) == 0)
			v = -v;
		return v;
	endfunction

	task automatic add_item(input func_t fn, input logic [63:0] op);
		conv_item_t it;
		it.fn = fn;
		it.operand = op;
		pending_items.push_back(it);
	endtask

	// ---------------------------------------------------------------
	// Driver: presents queued items, counts them in at each handshake,
	// and records what the converter should answer.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		conv_item_t it;
		if (!arst_n) begin
			start <= 1'b0;
			func <= '0;
			operand_bits <= '0;
		end else begin
			if (start && !busy) begin
				it.fn = func_t'(func);
				it.operand = operand_bits;
				expected_results.push_back(predict_conversion(it));
				items_accepted++;
			end
			// one decision per edge: start only changes value once
			if ((!start || !busy) && pending_items.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				start <= 1'b1;
				func <= it.fn;
				operand_bits <= it.operand;
			end else if (!start || !busy) begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: every done pulse is compared against the oldest entry.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		conv_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: result_bits=%h result_wide=%b",
					result_bits, result_wide);
				mismatch_seen = 1'b1;
			end else begin
				want = expected_results.pop_front();
				if (result_bits !== want.bits) begin
					$error("result_bits: expected %h, actual %h", want.bits, result_bits);
					mismatch_seen = 1'b1;
				end
				if (result_wide !== want.wide) begin
					$error("result_wide: expected %b, actual %b", want.wide, result_wide);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int total;
		// directed part: extremes and each corner of the conversions
		add_item(FN_I2L, 64'hDEAD_BEEF_8000_0000);   // upper half ignored
		add_item(FN_I2L, 64'h0000_0000_7FFF_FFFF);
		add_item(FN_I2F, 64'h0000_0000_7FFF_FFFF);   // rounds up to 2^31
		add_item(FN_I2F, 64'hFFFF_FFFF_0100_0001);   // tie to even
		add_item(FN_I2D, 64'h0000_0000_8000_0000);
		add_item(FN_I2D, 64'h0000_0000_0000_0000);   // integer zero -> +0
		add_item(FN_L2I, 64'h1234_5678_9ABC_DEF0);
		add_item(FN_L2F, 64'h8000_0000_0000_0000);
		add_item(FN_L2F, 64'h7FFF_FFFF_FFFF_FFFF);
		add_item(FN_L2D, 64'h0020_0000_0000_0001);   // tie to even
		add_item(FN_F2I, 64'h0000_0000_7FC0_0001);   // NaN -> 0
		add_item(FN_F2I, 64'h0000_0000_FF80_0000);   // -inf saturates
		add_item(FN_F2I, 64'hFFFF_FFFF_4F00_0000);   // 2^31 saturates
		add_item(FN_F2L, 64'h0000_0000_5F00_0000);   // 2^63 saturates
		add_item(FN_F2L, 64'h0000_0000_DF00_0000);   // exactly min long
		add_item(FN_F2D, 64'h0000_0000_0000_0001);   // smallest subnormal
		add_item(FN_F2D, 64'h0000_0000_FFC0_0001);   // NaN canonicalized
		add_item(FN_F2D, 64'h0000_0000_8000_0000);   // negative zero kept
		add_item(FN_D2I, 64'h41DF_FFFF_FFC0_0000);
		add_item(FN_D2I, 64'hFFF8_0000_0000_0001);
		add_item(FN_D2L, 64'hC3E0_0000_0000_0000);
		add_item(FN_D2F, 64'h3690_0000_0000_0000);   // halfway below the smallest float subnormal, rounds to zero
		add_item(FN_D2F, 64'h47EF_FFFF_FFFF_FFFF);   // rounds to infinity
		add_item(FN_D2F, 64'h8000_0000_0000_0000);
		add_item(FN_I2B, 64'h0000_0000_0000_0080);
		add_item(FN_I2C, 64'hFFFF_FFFF_FFFF_8000);
		add_item(FN_I2S, 64'h0000_0000_0000_8000);
		add_item(FN_NONE, '1);                        // unused selector
		for (int i = 0; i < RandomItems; i++)
			add_item(func_t'($urandom_range(0, 15)), pick_operand());
		total = pending_items.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// idle phases: sender idles a quarter of the time, then about half, then never
		wait (items_accepted >= total / 3);
		send_idle_pct = 49;
		wait (items_accepted >= (2 * total) / 3);
		send_idle_pct = 0;
		wait (items_accepted == total && expected_results.size() == 0);
		repeat (DrainCycles) @(posedge clk);

		if (!mismatch_seen && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[files.f]
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_front.sv
hw/rtl/ntc_queue.sv
hw/rtl/ntc_back.sv
hw/rtl/numeric_type_converter.sv
tb/tb.sv
